// File: rtl/bh_pkg.sv
// Shared types and constants for the byte histogram core.
package bh_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int BIN_FIELD_BITS = 7;
   localparam int FIELD_BITS     = 32;
   localparam int CMD_BIN_BITS   = 8;

   localparam logic REQ_KIND_COUNT = 1'b0;
   localparam logic REQ_KIND_READ  = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic [BYTE_BITS-1:0]      data_byte;
      logic [BIN_FIELD_BITS-1:0] bin_select;
      logic                      last_in_buffer;
   } bh_req_pkt_type;

   typedef struct packed {
      logic                      is_done;
      logic [BIN_FIELD_BITS-1:0] bin_index;
      logic [FIELD_BITS-1:0]     bin_count;
      logic [FIELD_BITS-1:0]     bytes_total;
      logic [FIELD_BITS-1:0]     dropped_total;
   } bh_rsp_pkt_type;

   typedef enum logic [1:0] {
      OP_COUNT_BIN,
      OP_COUNT_DROP,
      OP_READ_BIN,
      OP_READ_NONE
   } bh_op_type;

   typedef struct packed {
      bh_op_type                 op;
      logic [CMD_BIN_BITS-1:0]   bin;
      logic [BIN_FIELD_BITS-1:0] index;
      logic                      last;
   } bh_cmd_type;

   typedef struct packed {
      logic       valid;
      bh_cmd_type cmd;
   } bh_cmd_slot_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } bh_state_type;

endpackage

// File: rtl/bh_stream_if.sv
// Valid/ready stream channel carrying one request or response payload.
interface bh_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/bh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bh_front.sv
// Request intake: accepts requests and classifies them into bin commands.
module bh_front
   import bh_pkg::*;
#(
   parameter int NUM_BINS = 128
) (
   bh_stream_if.sink        req_chan,
   input  logic             queue_full,
   output bh_cmd_slot_type  push
);

   logic [BYTE_BITS:0] byte_ext;
   logic [BYTE_BITS:0] sel_ext;
   logic [BYTE_BITS:0] bins_ext;
   bh_req_pkt_type     pkt;

   assign pkt            = req_chan.payload;
   assign req_chan.ready = !queue_full;

   always_comb begin
      byte_ext = {1'b0, pkt.data_byte};
      sel_ext  = (BYTE_BITS + 1)'(pkt.bin_select);
      bins_ext = (BYTE_BITS + 1)'(NUM_BINS);

      push.valid     = req_chan.valid && !queue_full;
      push.cmd.index = pkt.bin_select;
      push.cmd.last  = pkt.last_in_buffer;
      if (pkt.req_type == REQ_KIND_READ) begin
         push.cmd.op  = (sel_ext < bins_ext) ? OP_READ_BIN : OP_READ_NONE;
         push.cmd.bin = CMD_BIN_BITS'(pkt.bin_select);
      end else begin
         push.cmd.op  = (byte_ext < bins_ext) ? OP_COUNT_BIN : OP_COUNT_DROP;
         push.cmd.bin = CMD_BIN_BITS'(pkt.data_byte);
      end
   end

endmodule

// File: rtl/bh_cmd_queue.sv
// Two-entry command queue between intake and execution.
module bh_cmd_queue
   import bh_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  bh_cmd_slot_type push,
   output logic            full,
   output bh_cmd_slot_type head,
   input  logic            pop
);

   bh_cmd_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push;
   logic        do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// File: rtl/bh_back.sv
// Command execution: bin read-modify-write, tallies and response register.
module bh_back
   import bh_pkg::*;
#(
   parameter int NUM_BINS   = 128,
   parameter int COUNT_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  bh_cmd_slot_type head,
   output logic            pop,
   bh_stream_if.source     rsp_chan
);

   localparam int BIN_BITS = $clog2(NUM_BINS);

   function automatic logic [FIELD_BITS-1:0] present(logic [COUNT_BITS-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return (wide > 64'h0000_0000_FFFF_FFFF) ? '1 : wide[FIELD_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + COUNT_BITS'(1);
   endfunction

   bh_state_type            state_ff, state_in;
   bh_cmd_type              cmd_ff, cmd_in;
   logic                    vld_rd_ff, vld_rd_in;
   logic [NUM_BINS-1:0]     bin_vld_ff, bin_vld_in;
   logic [COUNT_BITS-1:0]   byte_tally_ff, byte_tally_in;
   logic [COUNT_BITS-1:0]   drop_tally_ff, drop_tally_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bh_rsp_pkt_type          rsp_ff, rsp_in;

   logic [BIN_BITS-1:0]     rd_addr;
   logic [COUNT_BITS-1:0]   rd_data;
   logic [COUNT_BITS-1:0]   cur_count;
   logic                    wr_en;
   logic [COUNT_BITS-1:0]   wr_data;
   logic                    is_count;
   logic                    need_rsp;
   logic                    rsp_free;
   logic                    go;

   bh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_ff.bin[BIN_BITS-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      vld_rd_in     = vld_rd_ff;
      bin_vld_in    = bin_vld_ff;
      byte_tally_in = byte_tally_ff;
      drop_tally_in = drop_tally_ff;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      go            = 1'b0;

      rsp_free     = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      cur_count = vld_rd_ff ? rd_data : '0;
      wr_data   = sat_inc(cur_count);
      is_count  = (cmd_ff.op == OP_COUNT_BIN) || (cmd_ff.op == OP_COUNT_DROP);
      need_rsp  = !is_count || cmd_ff.last;
      rd_addr   = cmd_ff.bin[BIN_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = head.cmd.bin[BIN_BITS-1:0];
            if (head.valid) begin
               pop       = 1'b1;
               cmd_in    = head.cmd;
               vld_rd_in = bin_vld_ff[head.cmd.bin[BIN_BITS-1:0]];
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            go = !need_rsp || rsp_free;
            if (go) begin
               state_in = ST_IDLE;
               if (is_count) begin
                  byte_tally_in = sat_inc(byte_tally_ff);
               end
               if (cmd_ff.op == OP_COUNT_BIN) begin
                  wr_en = 1'b1;
                  bin_vld_in[cmd_ff.bin[BIN_BITS-1:0]] = 1'b1;
               end
               if (cmd_ff.op == OP_COUNT_DROP) begin
                  drop_tally_in = sat_inc(drop_tally_ff);
               end
               if (need_rsp) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.is_done       = is_count;
                  rsp_in.bin_index     = is_count ? '0 : cmd_ff.index;
                  rsp_in.bin_count     = (cmd_ff.op == OP_READ_BIN) ? present(cur_count) : '0;
                  rsp_in.bytes_total   = is_count ? present(byte_tally_in) : '0;
                  rsp_in.dropped_total = is_count ? present(drop_tally_in) : '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bin_vld_ff    <= '0;
         byte_tally_ff <= '0;
         drop_tally_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bin_vld_ff    <= bin_vld_in;
         byte_tally_ff <= byte_tally_in;
         drop_tally_ff <= drop_tally_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      vld_rd_ff <= vld_rd_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// File: rtl/byte_histogram_core.sv
// Top level of the byte histogram core: intake, command queue, execution.
//
//   channel    dir  handshake      payload
//   req_chan   in   valid/ready    bh_req_pkt_type (count byte or read bin)
//   rsp_chan   out  valid/ready    bh_rsp_pkt_type (bin read or completion)
//
// Execution reads the bin store in IDLE and finishes the read-modify-write in EXEC.
// A two-entry queue lets intake keep taking requests while execution works.
// Reset clears all bins (per-bin valid flags) and tallies at once; no clearing pass.
// A stalled response holds execution only when the next request also responds.
module byte_histogram_core
   import bh_pkg::*;
#(
   parameter int NUM_BINS   = 128,
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   bh_stream_if.sink   req_chan,
   bh_stream_if.source rsp_chan
);

   bh_cmd_slot_type push;
   bh_cmd_slot_type head;
   logic            queue_full;
   logic            pop;

   bh_front #(
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   bh_cmd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   bh_back #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: tb/sv/tb_byte_histogram_core.sv
// Self-checking testbench for byte_histogram_core: directed and random requests.
module tb_byte_histogram_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bh_pkg::*;

   localparam int NUM_BINS     = 128;
   localparam int COUNT_BITS   = 32;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 8;
   localparam int PHASE_ITEMS  = 125;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_ITEMS   = 40;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

   logic clock = 1'b0;
   logic reset;

   bh_stream_if #(.payload_type(bh_req_pkt_type)) req_if ();
   bh_stream_if #(.payload_type(bh_rsp_pkt_type)) rsp_if ();

   byte_histogram_core #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // histogram image
   logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
   logic [COUNT_BITS-1:0] hist_bytes;
   logic [COUNT_BITS-1:0] hist_dropped;
   bh_rsp_pkt_type        expected_rsp_q [$];

   int unsigned      error_count   = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      rsp_stall_pct = 0;
   logic             rsp_hold      = 1'b0;
   logic [7:0]       recent_byte   = '0;
   event             rsp_hold_go;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [COUNT_BITS-1:0] v);
      if (COUNT_BITS > FIELD_BITS && v > COUNT_BITS'(FIELD_MAX))
         return FIELD_MAX;
      return FIELD_BITS'(v);
   endfunction

   task automatic predict_histogram(input bh_req_pkt_type req);
      bh_rsp_pkt_type rsp;
      rsp = '0;
      if (req.req_type == REQ_KIND_COUNT) begin
         hist_bytes = sat_inc(hist_bytes);
         if (req.data_byte < NUM_BINS)
            hist_bins[req.data_byte[6:0]] = sat_inc(hist_bins[req.data_byte[6:0]]);
         else
            hist_dropped = sat_inc(hist_dropped);
         if (req.last_in_buffer) begin
            rsp.is_done       = 1'b1;
            rsp.bytes_total   = to_field(hist_bytes);
            rsp.dropped_total = to_field(hist_dropped);
            expected_rsp_q.push_back(rsp);
         end
      end else begin
         rsp.bin_index = req.bin_select;
         rsp.bin_count = (req.bin_select < NUM_BINS) ? to_field(hist_bins[req.bin_select]) : '0;
         expected_rsp_q.push_back(rsp);
      end
   endtask

   // call at a rising edge; returns at the edge where the request was taken
   task automatic send_request(input bh_req_pkt_type req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= req;
      do @(posedge clock); while (!req_if.ready);
      predict_histogram(req);
   endtask

   function automatic bh_req_pkt_type make_request(input logic kind, input logic [7:0] data,
                                                   input logic [6:0] sel, input logic last);
      bh_req_pkt_type req;
      req.req_type       = kind;
      req.data_byte      = data;
      req.bin_select     = sel;
      req.last_in_buffer = last;
      return req;
   endfunction

   function automatic bh_req_pkt_type random_request();
      bh_req_pkt_type req;
      int unsigned    roll;
      req  = make_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                          7'($urandom_range(127)), 1'($urandom_range(1)));
      roll = $urandom_range(99);
      if (roll < 60) begin
         req.req_type       = REQ_KIND_COUNT;
         req.last_in_buffer = ($urandom_range(9) == 0);
         if ($urandom_range(3) == 0)
            req.data_byte = recent_byte;
         recent_byte = req.data_byte;
      end else if (roll < 95) begin
         req.req_type = REQ_KIND_READ;
         if ($urandom_range(1) == 1)
            req.bin_select = recent_byte[6:0];
      end
      return req;
   endfunction

   task automatic run_random_requests(input int unsigned n);
      repeat (n) send_request(random_request());
   endtask

   task automatic check_field(input string name, input logic [FIELD_BITS-1:0] want,
                              input logic [FIELD_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // response check
   always @(posedge clock) begin : rsp_check
      bh_rsp_pkt_type want;
      bh_rsp_pkt_type got;
      got = rsp_if.payload;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response %p", got);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("is_done", FIELD_BITS'(want.is_done), FIELD_BITS'(got.is_done));
            check_field("bin_index", FIELD_BITS'(want.bin_index), FIELD_BITS'(got.bin_index));
            check_field("bin_count", want.bin_count, got.bin_count);
            check_field("bytes_total", want.bytes_total, got.bytes_total);
            check_field("dropped_total", want.dropped_total, got.dropped_total);
         end
      end
   end

   always @(posedge clock)
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);

   initial begin
      forever begin
         @(rsp_hold_go);
         rsp_hold = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(make_request(REQ_KIND_READ, 8'hFF, 7'd0, 1'b1));
      send_request(make_request(REQ_KIND_READ, 8'h00, 7'd127, 1'b0));
      send_request(make_request(REQ_KIND_COUNT, 8'd0, 7'd127, 1'b0));
      send_request(make_request(REQ_KIND_COUNT, 8'd127, 7'd0, 1'b0));
      send_request(make_request(REQ_KIND_COUNT, 8'd128, 7'd0, 1'b0));
      send_request(make_request(REQ_KIND_COUNT, 8'd255, 7'd127, 1'b1));
      send_request(make_request(REQ_KIND_READ, 8'd0, 7'd0, 1'b0));
      send_request(make_request(REQ_KIND_READ, 8'hFF, 7'd127, 1'b0));
      // same bin back to back, then read it at once
      send_request(make_request(REQ_KIND_COUNT, 8'd5, 7'd0, 1'b0));
      send_request(make_request(REQ_KIND_COUNT, 8'd5, 7'd0, 1'b0));
      send_request(make_request(REQ_KIND_COUNT, 8'd5, 7'd0, 1'b0));
      send_request(make_request(REQ_KIND_READ, 8'd0, 7'd5, 1'b0));
      send_request(make_request(REQ_KIND_COUNT, 8'd200, 7'd5, 1'b1));
      send_request(make_request(REQ_KIND_COUNT, 8'd5, 7'd0, 1'b1));
      send_request(make_request(REQ_KIND_READ, 8'd5, 7'd5, 1'b1));
      send_request(make_request(REQ_KIND_READ, 8'd128, 7'd72, 1'b0));
   endtask

   task automatic test_random_streaming();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_requests(PHASE_ITEMS);
   endtask

   task automatic test_random_sender_gaps();
      send_idle_pct = 74;
      rsp_stall_pct = 0;
      run_random_requests(PHASE_ITEMS);
   endtask

   task automatic test_random_receiver_stalls();
      send_idle_pct = 0;
      rsp_stall_pct = 74;
      run_random_requests(PHASE_ITEMS);
   endtask

   task automatic test_random_mixed_idle();
      send_idle_pct = 13;
      rsp_stall_pct = 13;
      run_random_requests(PHASE_ITEMS);
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> rsp_hold_go;
      repeat (HOLD_ITEMS)
         send_request(make_request(REQ_KIND_READ, 8'($urandom_range(255)),
                                   7'($urandom_range(127)), 1'($urandom_range(1))));
   endtask

   initial begin
      hist_bins      = '{default: '0};
      hist_bytes     = '0;
      hist_dropped   = '0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_streaming();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_mixed_idle();
      test_output_backpressure();
      test_random_streaming();

      req_if.valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
rtl/bh_pkg.sv
rtl/bh_stream_if.sv
rtl/bh_ram.sv
rtl/bh_front.sv
rtl/bh_cmd_queue.sv
rtl/bh_back.sv
rtl/byte_histogram_core.sv
tb/sv/tb_byte_histogram_core.sv
